FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define VAU_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("vau assertion failed");

// Check a property on every clock edge, reset included.
`define VAU_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("vau assertion failed");

`endif

FILE: design/vau_pkg.sv
// ----------------------------------------------------------------------------
// vau_pkg
// Types and constants of the 2D vector arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vau_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned FracW    = 16;
  localparam int unsigned SumW     = 2 * CoordW + 1;
  localparam int unsigned SqSteps  = (SumW + 1) / 2;
  localparam int unsigned DivSteps = FracW + 1;
  localparam int unsigned QuotW    = DivSteps;

  typedef enum logic [2:0] {
    ModeAdd    = 3'd0,
    ModeSub    = 3'd1,
    ModeScale  = 3'd2,
    ModeLength = 3'd3,
    ModeNorm   = 3'd4
  } mode_e;

  // Per-item side data carried along the pipeline
  typedef struct packed {
    logic              is_len;
    logic              is_norm;
    logic              zero;
    logic              sat;
    logic              neg_x;
    logic              neg_y;
    logic [CoordW-1:0] rx;
    logic [CoordW-1:0] ry;
    logic [CoordW-1:0] ux;
    logic [CoordW-1:0] uy;
  } side_t;

endpackage

`default_nettype wire

FILE: design/vector_arith_unit_2d_core.sv
// ----------------------------------------------------------------------------
// vector_arith_unit_2d_core
// Add, subtract, scale, length and normalize of signed Q16.16 2D vectors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i with mode_i, a_x_i, a_y_i, b_x_i, b_y_i and
//   multiplier_i; an item is taken when in_valid_i is high and in_stall_o
//   is low. Output channel: out_valid_o with result_x_o, result_y_o,
//   magnitude_o, zero_vector_o and saturated_o; an item leaves when
//   out_valid_o is high and out_stall_i is low.
//   Every item gives exactly one result, in order, whatever its mode. One
//   item is taken per cycle while in_stall_o is low: the square root
//   (one root bit per stage, 33 stages) and the divider (one quotient bit
//   per stage, 17 stages) are fully pipelined.
//   When out_stall_i is high while a result is waiting, the whole pipeline
//   holds and in_stall_o goes high in the same cycle; nothing is lost or
//   repeated. Reset clears all valid bits; the unit keeps no other state.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_arith_unit_2d_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 mode_i,
  input  logic [vau_pkg::CoordW-1:0] a_x_i,
  input  logic [vau_pkg::CoordW-1:0] a_y_i,
  input  logic [vau_pkg::CoordW-1:0] b_x_i,
  input  logic [vau_pkg::CoordW-1:0] b_y_i,
  input  logic [vau_pkg::CoordW-1:0] multiplier_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [vau_pkg::CoordW-1:0] result_x_o,
  output logic [vau_pkg::CoordW-1:0] result_y_o,
  output logic [vau_pkg::CoordW-1:0] magnitude_o,
  output logic                       zero_vector_o,
  output logic                       saturated_o
);
  import vau_pkg::*;

  logic en;
  logic out_valid_q;

  // hold every stage while a result waits at a stalled receiver
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  logic              fr_valid;
  logic [SumW-1:0]   fr_sum;
  side_t             fr_side;

  vau_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_valid_i),
    .mode_i       (mode_i),
    .a_x_i        (a_x_i),
    .a_y_i        (a_y_i),
    .b_x_i        (b_x_i),
    .b_y_i        (b_y_i),
    .multiplier_i (multiplier_i),
    .valid_o      (fr_valid),
    .sumsq_o      (fr_sum),
    .side_o       (fr_side)
  );

  logic              sq_valid;
  logic [CoordW-1:0] sq_mag;
  side_t             sq_side;

  vau_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .sumsq_i (fr_sum),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .mag_o   (sq_mag),
    .side_o  (sq_side)
  );

  logic              dv_valid;
  logic [CoordW-1:0] dv_mag, dv_nx, dv_ny;
  side_t             dv_side;

  vau_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .mag_i   (sq_mag),
    .side_i  (sq_side),
    .valid_o (dv_valid),
    .mag_o   (dv_mag),
    .nx_o    (dv_nx),
    .ny_o    (dv_ny),
    .side_o  (dv_side)
  );

  // result select
  logic              norm_ok;
  logic [CoordW-1:0] rx_d, ry_d, mag_d;
  logic              zero_d, sat_d;

  assign norm_ok = dv_side.is_norm && !dv_side.zero;
  assign rx_d    = norm_ok ? dv_nx : dv_side.rx;
  assign ry_d    = norm_ok ? dv_ny : dv_side.ry;
  assign mag_d   = (dv_side.is_len || norm_ok) ? dv_mag : '0;
  assign zero_d  = dv_side.is_norm && dv_side.zero;
  assign sat_d   = norm_ok ? 1'b0 : dv_side.sat;

  logic [CoordW-1:0] rx_q, ry_q, mag_q;
  logic              zero_q, sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q   <= rx_d;
      ry_q   <= ry_d;
      mag_q  <= mag_d;
      zero_q <= zero_d;
      sat_q  <= sat_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_x_o    = rx_q;
  assign result_y_o    = ry_q;
  assign magnitude_o   = mag_q;
  assign zero_vector_o = zero_q;
  assign saturated_o   = sat_q;

endmodule

`default_nettype wire

FILE: design/vau_front.sv
// ----------------------------------------------------------------------------
// vau_front
// Input register, multipliers, add/subtract/scale results and sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module vau_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [2:0]                    mode_i,
  input  logic [vau_pkg::CoordW-1:0]    a_x_i,
  input  logic [vau_pkg::CoordW-1:0]    a_y_i,
  input  logic [vau_pkg::CoordW-1:0]    b_x_i,
  input  logic [vau_pkg::CoordW-1:0]    b_y_i,
  input  logic [vau_pkg::CoordW-1:0]    multiplier_i,
  output logic                          valid_o,
  output logic [vau_pkg::SumW-1:0]      sumsq_o,
  output vau_pkg::side_t                side_o
);
  import vau_pkg::*;

  localparam int unsigned ProdW = 2 * CoordW;
  localparam int unsigned ScW   = ProdW + 1 - FracW;

  function automatic logic [CoordW:0] scale_fix(input logic [ScW-1:0] m, input logic neg);
    logic [ScW-1:0]    lim;
    logic [CoordW-1:0] v;
    logic              s;
    lim = neg ? (ScW'(1) << (CoordW - 1)) : ((ScW'(1) << (CoordW - 1)) - ScW'(1));
    s   = m > lim;
    v   = s ? lim[CoordW-1:0] : m[CoordW-1:0];
    if (neg) v = ~v + 1'b1;
    return {s, v};
  endfunction

  function automatic logic [CoordW:0] sat_fix(input logic [CoordW:0] v);
    logic [CoordW-1:0] r;
    logic              s;
    s = v[CoordW] != v[CoordW-1];
    r = v[CoordW-1:0];
    if (s) r = v[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    return {s, r};
  endfunction

  // stage 0: input register
  logic              v0_q;
  logic [2:0]        mode0_q;
  logic [CoordW-1:0] ax0_q, ay0_q, bx0_q, by0_q, mul0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode0_q <= mode_i;
      ax0_q   <= a_x_i;
      ay0_q   <= a_y_i;
      bx0_q   <= b_x_i;
      by0_q   <= b_y_i;
      mul0_q  <= multiplier_i;
    end
  end

  // stage 1: magnitudes, products, sums
  logic [CoordW-1:0] ux_c, uy_c, um_c;
  logic [ProdW-1:0]  sqx_c, sqy_c, px_c, py_c;
  logic [CoordW:0]   sx_c, sy_c;

  assign ux_c  = ax0_q[CoordW-1] ? (~ax0_q + 1'b1) : ax0_q;
  assign uy_c  = ay0_q[CoordW-1] ? (~ay0_q + 1'b1) : ay0_q;
  assign um_c  = mul0_q[CoordW-1] ? (~mul0_q + 1'b1) : mul0_q;
  assign sqx_c = ProdW'(ux_c) * ProdW'(ux_c);
  assign sqy_c = ProdW'(uy_c) * ProdW'(uy_c);
  assign px_c  = ProdW'(ux_c) * ProdW'(um_c);
  assign py_c  = ProdW'(uy_c) * ProdW'(um_c);
  assign sx_c  = (mode0_q == ModeSub)
               ? ({ax0_q[CoordW-1], ax0_q} - {bx0_q[CoordW-1], bx0_q})
               : ({ax0_q[CoordW-1], ax0_q} + {bx0_q[CoordW-1], bx0_q});
  assign sy_c  = (mode0_q == ModeSub)
               ? ({ay0_q[CoordW-1], ay0_q} - {by0_q[CoordW-1], by0_q})
               : ({ay0_q[CoordW-1], ay0_q} + {by0_q[CoordW-1], by0_q});

  logic              v1_q;
  logic [2:0]        mode1_q;
  logic [ProdW-1:0]  sqx1_q, sqy1_q, px1_q, py1_q;
  logic [CoordW:0]   sx1_q, sy1_q;
  logic [CoordW-1:0] ux1_q, uy1_q;
  logic              negx1_q, negy1_q, negm1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode1_q <= mode0_q;
      sqx1_q  <= sqx_c;
      sqy1_q  <= sqy_c;
      px1_q   <= px_c;
      py1_q   <= py_c;
      sx1_q   <= sx_c;
      sy1_q   <= sy_c;
      ux1_q   <= ux_c;
      uy1_q   <= uy_c;
      negx1_q <= ax0_q[CoordW-1];
      negy1_q <= ay0_q[CoordW-1];
      negm1_q <= mul0_q[CoordW-1];
    end
  end

  // stage 2: sum of squares, rounding and clamping
  logic [SumW-1:0]   sum_c;
  logic [ProdW:0]    tx_c, ty_c;
  logic [CoordW:0]   fx_c, fy_c;
  side_t             side_c;

  assign sum_c = {1'b0, sqx1_q} + {1'b0, sqy1_q};
  assign tx_c  = {1'b0, px1_q} + ((ProdW + 1)'(1) << (FracW - 1));
  assign ty_c  = {1'b0, py1_q} + ((ProdW + 1)'(1) << (FracW - 1));

  always_comb begin
    side_c       = '0;
    side_c.ux    = ux1_q;
    side_c.uy    = uy1_q;
    side_c.neg_x = negx1_q;
    side_c.neg_y = negy1_q;
    fx_c         = '0;
    fy_c         = '0;
    case (mode1_q) inside
      ModeAdd, ModeSub: begin
        fx_c = sat_fix(sx1_q);
        fy_c = sat_fix(sy1_q);
      end
      ModeScale: begin
        fx_c = scale_fix(tx_c[ProdW:FracW], negx1_q ^ negm1_q);
        fy_c = scale_fix(ty_c[ProdW:FracW], negy1_q ^ negm1_q);
      end
      ModeLength: begin
        side_c.is_len = 1'b1;
      end
      ModeNorm: begin
        side_c.is_norm = 1'b1;
        side_c.zero    = (ux1_q == '0) && (uy1_q == '0);
      end
      default: begin
      end
    endcase
    side_c.rx  = fx_c[CoordW-1:0];
    side_c.ry  = fy_c[CoordW-1:0];
    side_c.sat = fx_c[CoordW] | fy_c[CoordW];
  end

  logic            v2_q;
  logic [SumW-1:0] sum2_q;
  side_t           side2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum2_q  <= sum_c;
      side2_q <= side_c;
    end
  end

  assign valid_o = v2_q;
  assign sumsq_o = sum2_q;
  assign side_o  = side2_q;

endmodule

`default_nettype wire

FILE: design/vau_sqrt.sv
// ----------------------------------------------------------------------------
// vau_sqrt
// Pipelined digit-by-digit square root, one root bit per stage, then rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module vau_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [vau_pkg::SumW-1:0]   sumsq_i,
  input  vau_pkg::side_t             side_i,
  output logic                       valid_o,
  output logic [vau_pkg::CoordW-1:0] mag_o,
  output vau_pkg::side_t             side_o
);
  import vau_pkg::*;

  localparam int unsigned NW    = 2 * SqSteps;
  localparam int unsigned RootW = SqSteps;
  localparam int unsigned RemW  = SqSteps + 3;

  logic             v_q    [SqSteps];
  logic [NW-1:0]    n_q    [SqSteps];
  logic [RemW-1:0]  rem_q  [SqSteps];
  logic [RootW-1:0] root_q [SqSteps];
  side_t            side_q [SqSteps];

  for (genvar k = 0; k < SqSteps; k++) begin : g_step
    logic             v_in;
    logic [NW-1:0]    n_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    side_t            side_in;
    logic [RemW-1:0]  cur, trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign n_in    = NW'(sumsq_i);
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign n_in    = n_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down the next two bits and try the next root bit
    assign cur   = {rem_in[RemW-3:0], n_in[NW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]    <= {n_in[NW-3:0], 2'b00};
        rem_q[k]  <= ge ? (cur - trial) : cur;
        root_q[k] <= {root_in[RootW-2:0], ge};
        side_q[k] <= side_in;
      end
    end
  end

  // round to nearest: up when the remainder exceeds the root
  logic [RootW-1:0]  root_l;
  logic [RemW-1:0]   rem_l;
  logic              up_c;
  logic [RootW-1:0]  rsum_c;

  assign root_l = root_q[SqSteps-1];
  assign rem_l  = rem_q[SqSteps-1];
  assign up_c   = rem_l > RemW'(root_l);
  assign rsum_c = root_l + RootW'(up_c);

  logic              vr_q;
  logic [CoordW-1:0] mag_q;
  side_t             sider_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else if (en_i) begin
      vr_q <= v_q[SqSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q   <= rsum_c[CoordW-1:0];
      sider_q <= side_q[SqSteps-1];
    end
  end

  assign valid_o = vr_q;
  assign mag_o   = mag_q;
  assign side_o  = sider_q;

endmodule

`default_nettype wire

FILE: design/vau_div.sv
// ----------------------------------------------------------------------------
// vau_div
// Two-lane pipelined restoring divider for normalize, one quotient bit per
// stage, then round-to-nearest and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module vau_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [vau_pkg::CoordW-1:0] mag_i,
  input  vau_pkg::side_t             side_i,
  output logic                       valid_o,
  output logic [vau_pkg::CoordW-1:0] mag_o,
  output logic [vau_pkg::CoordW-1:0] nx_o,
  output logic [vau_pkg::CoordW-1:0] ny_o,
  output vau_pkg::side_t             side_o
);
  import vau_pkg::*;

  logic              v_q    [DivSteps];
  logic [CoordW-1:0] m_q    [DivSteps];
  logic [CoordW-1:0] remx_q [DivSteps];
  logic [CoordW-1:0] remy_q [DivSteps];
  logic [QuotW-1:0]  qx_q   [DivSteps];
  logic [QuotW-1:0]  qy_q   [DivSteps];
  side_t             side_q [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic              v_in;
    logic [CoordW-1:0] m_in;
    logic [QuotW-1:0]  qx_in, qy_in;
    side_t             side_in;
    logic [CoordW:0]   curx, cury, difx, dify;
    logic              gex, gey;

    if (k == 0) begin : g_first
      // the vector's component never exceeds its length: top bit first
      assign v_in    = valid_i;
      assign m_in    = mag_i;
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign side_in = side_i;
      assign curx    = {1'b0, side_i.ux};
      assign cury    = {1'b0, side_i.uy};
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign m_in    = m_q[k-1];
      assign qx_in   = qx_q[k-1];
      assign qy_in   = qy_q[k-1];
      assign side_in = side_q[k-1];
      assign curx    = {remx_q[k-1], 1'b0};
      assign cury    = {remy_q[k-1], 1'b0};
    end

    assign difx = curx - {1'b0, m_in};
    assign dify = cury - {1'b0, m_in};
    assign gex  = curx >= {1'b0, m_in};
    assign gey  = cury >= {1'b0, m_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k]    <= m_in;
        remx_q[k] <= gex ? difx[CoordW-1:0] : curx[CoordW-1:0];
        remy_q[k] <= gey ? dify[CoordW-1:0] : cury[CoordW-1:0];
        qx_q[k]   <= {qx_in[QuotW-2:0], gex};
        qy_q[k]   <= {qy_in[QuotW-2:0], gey};
        side_q[k] <= side_in;
      end
    end
  end

  // round half away from zero, then apply the component's sign
  localparam int unsigned L = DivSteps - 1;

  logic              upx_c, upy_c;
  logic [QuotW:0]    qrx_c, qry_c;
  logic [CoordW-1:0] ax_c, ay_c;

  assign upx_c = {remx_q[L], 1'b0} >= {1'b0, m_q[L]};
  assign upy_c = {remy_q[L], 1'b0} >= {1'b0, m_q[L]};
  assign qrx_c = {1'b0, qx_q[L]} + (QuotW + 1)'(upx_c);
  assign qry_c = {1'b0, qy_q[L]} + (QuotW + 1)'(upy_c);
  assign ax_c  = CoordW'(qrx_c);
  assign ay_c  = CoordW'(qry_c);

  logic              vr_q;
  logic [CoordW-1:0] magr_q, nx_q, ny_q;
  side_t             sider_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else if (en_i) begin
      vr_q <= v_q[L];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      magr_q  <= m_q[L];
      nx_q    <= side_q[L].neg_x ? (~ax_c + 1'b1) : ax_c;
      ny_q    <= side_q[L].neg_y ? (~ay_c + 1'b1) : ay_c;
      sider_q <= side_q[L];
    end
  end

  assign valid_o = vr_q;
  assign mag_o   = magr_q;
  assign nx_o    = nx_q;
  assign ny_o    = ny_q;
  assign side_o  = sider_q;

endmodule

`default_nettype wire

FILE: design/vau_checker.sv
// ----------------------------------------------------------------------------
// vau_checker
// Port-level checks of the vector arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module vau_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_stall_o,
  input  logic                       out_valid_o,
  input  logic                       out_stall_i,
  input  logic [vau_pkg::CoordW-1:0] result_x_o,
  input  logic [vau_pkg::CoordW-1:0] result_y_o,
  input  logic [vau_pkg::CoordW-1:0] magnitude_o,
  input  logic                       zero_vector_o,
  input  logic                       saturated_o
);

  // no result shows while in reset
  `VAU_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_ni |-> !out_valid_o)

  // input is held back only by a stalled, waiting result
  `VAU_ASSERT(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i))

  // a stalled result holds
  `VAU_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o &&
    $stable(result_x_o) && $stable(result_y_o) && $stable(magnitude_o)))

  // zero-vector normalize gives an all-zero result
  `VAU_ASSERT(a_zero_result, (out_valid_o && zero_vector_o) |-> (result_x_o == '0 &&
    result_y_o == '0 && magnitude_o == '0 && !saturated_o))

  // only add, subtract and scale clamp, and they report no length
  `VAU_ASSERT(a_sat_no_mag, (out_valid_o && saturated_o) |-> (magnitude_o == '0))

endmodule

bind vector_arith_unit_2d_core vau_checker u_vau_checker (.*);

`default_nettype wire
